// File: rtl/ipid_pkg.sv
// Shared types and constants of the incremental PID height hold core.
package ipid_pkg;

   localparam int GAIN_FRAC_BITS = 8;

   localparam int GAIN_W    = 16;
   localparam int HEIGHT_W  = 12;
   localparam int BAND_W    = 8;
   localparam int FLOOR_W   = 12;
   localparam int CEIL_W    = 11;
   localparam int THR_W     = 11;
   localparam int ERR_W     = 13;
   localparam int TERM_W    = 12;
   localparam int DRIVE_W   = 13;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P         = 3'd0,
      REG_GAIN_I         = 3'd1,
      REG_GAIN_D         = 3'd2,
      REG_HEIGHT_CEILING = 3'd3,
      REG_DEAD_BAND      = 3'd4,
      REG_TERM_FLOOR     = 3'd5,
      REG_TERM_CEILING   = 3'd6
   } csr_index_type;

   localparam logic [GAIN_W-1:0]          GAIN_P_RESET    = 16'd256;
   localparam logic [GAIN_W-1:0]          GAIN_I_RESET    = 16'd0;
   localparam logic [GAIN_W-1:0]          GAIN_D_RESET    = 16'd0;
   localparam logic [HEIGHT_W-1:0]        CEILING_RESET   = 12'd1000;
   localparam logic [BAND_W-1:0]          BAND_RESET      = 8'd20;
   localparam logic signed [FLOOR_W-1:0]  FLOOR_RESET     = -12'sd50;
   localparam logic [CEIL_W-1:0]          TERM_CEIL_RESET = 11'd200;

   typedef struct packed {
      logic [GAIN_W-1:0]         gain_p;
      logic [GAIN_W-1:0]         gain_i;
      logic [GAIN_W-1:0]         gain_d;
      logic [HEIGHT_W-1:0]       height_ceiling;
      logic [BAND_W-1:0]         dead_band;
      logic signed [FLOOR_W-1:0] term_floor;
      logic [CEIL_W-1:0]         term_ceiling;
   } cfg_type;

   typedef struct packed {
      logic                      update;
      logic signed [ERR_W-1:0]   error;
      logic signed [TERM_W-1:0]  term;
      logic signed [DRIVE_W-1:0] drive;
   } calc_type;

endpackage

// File: rtl/ipid_csr.sv
// Configuration register file of the incremental PID height hold core.
module ipid_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ipid_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ipid_pkg::CSR_DAT_W-1:0]    csr_wdata,
   output ipid_pkg::cfg_type                 cfg
);

   ipid_pkg::cfg_type cfg_ff;
   ipid_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (ipid_pkg::csr_index_type'(csr_index))
            ipid_pkg::REG_GAIN_P:         cfg_in.gain_p = csr_wdata;
            ipid_pkg::REG_GAIN_I:         cfg_in.gain_i = csr_wdata;
            ipid_pkg::REG_GAIN_D:         cfg_in.gain_d = csr_wdata;
            ipid_pkg::REG_HEIGHT_CEILING: cfg_in.height_ceiling =
                                             csr_wdata[ipid_pkg::HEIGHT_W-1:0];
            ipid_pkg::REG_DEAD_BAND:      cfg_in.dead_band =
                                             csr_wdata[ipid_pkg::BAND_W-1:0];
            ipid_pkg::REG_TERM_FLOOR:     cfg_in.term_floor =
                                             $signed(csr_wdata[ipid_pkg::FLOOR_W-1:0]);
            ipid_pkg::REG_TERM_CEILING:   cfg_in.term_ceiling =
                                             csr_wdata[ipid_pkg::CEIL_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= ipid_pkg::GAIN_P_RESET;
         cfg_ff.gain_i         <= ipid_pkg::GAIN_I_RESET;
         cfg_ff.gain_d         <= ipid_pkg::GAIN_D_RESET;
         cfg_ff.height_ceiling <= ipid_pkg::CEILING_RESET;
         cfg_ff.dead_band      <= ipid_pkg::BAND_RESET;
         cfg_ff.term_floor     <= ipid_pkg::FLOOR_RESET;
         cfg_ff.term_ceiling   <= ipid_pkg::TERM_CEIL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/ipid_calc.sv
// Error, deadband test, incremental PID term, saturation and drive sum.
module ipid_calc (
   input  ipid_pkg::cfg_type                         cfg,
   input  logic [ipid_pkg::HEIGHT_W-1:0]             target_height,
   input  logic [ipid_pkg::HEIGHT_W-1:0]             measured_height,
   input  logic [ipid_pkg::THR_W-1:0]                base_throttle,
   input  logic signed [ipid_pkg::ERR_W-1:0]         last_error,
   input  logic signed [ipid_pkg::ERR_W-1:0]         older_error,
   output ipid_pkg::calc_type                        result
);

   localparam int DP_W   = ipid_pkg::ERR_W + 1;
   localparam int DD_W   = ipid_pkg::ERR_W + 3;
   localparam int GS_W   = ipid_pkg::GAIN_W + 1;
   localparam int PP_W   = GS_W + DP_W;
   localparam int PI_W   = GS_W + ipid_pkg::ERR_W;
   localparam int PD_W   = GS_W + DD_W;
   localparam int ACC_W  = PD_W + 1;

   logic [ipid_pkg::HEIGHT_W-1:0]        tgt;
   logic signed [ipid_pkg::ERR_W-1:0]    err;
   logic [ipid_pkg::ERR_W-1:0]           mag;
   logic signed [DP_W-1:0]               diff_p;
   logic signed [DD_W-1:0]               diff_d;
   logic signed [PP_W-1:0]               prod_p;
   logic signed [PI_W-1:0]               prod_i;
   logic signed [PD_W-1:0]               prod_d;
   logic signed [ACC_W-1:0]              acc;
   logic signed [ACC_W-1:0]              shifted;
   logic signed [ipid_pkg::TERM_W-1:0]   term;

   always_comb begin
      tgt = (target_height > cfg.height_ceiling) ? cfg.height_ceiling : target_height;
      err = $signed({1'b0, tgt}) - $signed({1'b0, measured_height});
      mag = err[ipid_pkg::ERR_W-1] ? ipid_pkg::ERR_W'(-err) : ipid_pkg::ERR_W'(err);

      diff_p = DP_W'(err) - DP_W'(last_error);
      diff_d = DD_W'(err) - (DD_W'(last_error) <<< 1) + DD_W'(older_error);

      prod_p = $signed({1'b0, cfg.gain_p}) * diff_p;
      prod_i = $signed({1'b0, cfg.gain_i}) * err;
      prod_d = $signed({1'b0, cfg.gain_d}) * diff_d;

      acc     = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);
      shifted = acc >>> ipid_pkg::GAIN_FRAC_BITS;

      if (shifted > ACC_W'($signed({1'b0, cfg.term_ceiling}))) begin
         term = ipid_pkg::TERM_W'($signed({1'b0, cfg.term_ceiling}));
      end else if (shifted < ACC_W'(cfg.term_floor)) begin
         term = cfg.term_floor;
      end else begin
         term = shifted[ipid_pkg::TERM_W-1:0];
      end

      result.update = (mag > ipid_pkg::ERR_W'(cfg.dead_band));
      result.error  = err;
      result.term   = term;
      result.drive  = ipid_pkg::DRIVE_W'($signed({1'b0, base_throttle}))
                    + ipid_pkg::DRIVE_W'(term);
   end

endmodule

// File: rtl/incremental_pid_height_hold_core.sv
// Top level of the incremental PID height hold core: input and result registers and state.
// Path: a request accepted goes into the input register, then into the result register once the output is free.
// Throughput: one transaction per cycle while rsp_ready keeps the output free; on an update the error history is
// written back in the same cycle as the result register, so the following sample sees it without a bubble.
// Reset: synchronous; gains and limits return to their defaults and the error history
// and held outputs clear to zero. No clearing pass is needed.
module incremental_pid_height_hold_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [ipid_pkg::HEIGHT_W-1:0]           req_target_height,
   input  logic [ipid_pkg::HEIGHT_W-1:0]           req_measured_height,
   input  logic [ipid_pkg::THR_W-1:0]              req_base_throttle,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [ipid_pkg::DRIVE_W-1:0]     rsp_drive_out,
   output logic signed [ipid_pkg::TERM_W-1:0]      rsp_pid_term,
   output logic                                    rsp_updated,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ipid_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ipid_pkg::CSR_DAT_W-1:0]          csr_wdata
);

   ipid_pkg::cfg_type  cfg;
   ipid_pkg::calc_type calc;

   logic                                 s1_valid_ff;
   logic [ipid_pkg::HEIGHT_W-1:0]        s1_target_ff;
   logic [ipid_pkg::HEIGHT_W-1:0]        s1_measured_ff;
   logic [ipid_pkg::THR_W-1:0]           s1_throttle_ff;

   logic signed [ipid_pkg::ERR_W-1:0]    last_error_ff;
   logic signed [ipid_pkg::ERR_W-1:0]    older_error_ff;
   logic signed [ipid_pkg::DRIVE_W-1:0]  held_drive_ff;
   logic signed [ipid_pkg::TERM_W-1:0]   held_term_ff;
   logic signed [ipid_pkg::DRIVE_W-1:0]  held_drive_in;
   logic signed [ipid_pkg::TERM_W-1:0]   held_term_in;

   logic                                 rsp_valid_ff;
   logic signed [ipid_pkg::DRIVE_W-1:0]  rsp_drive_ff;
   logic signed [ipid_pkg::TERM_W-1:0]   rsp_term_ff;
   logic                                 rsp_updated_ff;

   logic out_free;
   logic s1_fire;
   logic req_fire;

   ipid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ipid_calc u_calc (
      .cfg             (cfg),
      .target_height   (s1_target_ff),
      .measured_height (s1_measured_ff),
      .base_throttle   (s1_throttle_ff),
      .last_error      (last_error_ff),
      .older_error     (older_error_ff),
      .result          (calc)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign req_fire  = req_valid && req_ready;

   assign held_drive_in = calc.update ? calc.drive : held_drive_ff;
   assign held_term_in  = calc.update ? calc.term  : held_term_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_out = rsp_drive_ff;
   assign rsp_pid_term  = rsp_term_ff;
   assign rsp_updated   = rsp_updated_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_error_ff  <= '0;
         older_error_ff <= '0;
         held_drive_ff  <= '0;
         held_term_ff   <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_fire && calc.update) begin
            older_error_ff <= last_error_ff;
            last_error_ff  <= calc.error;
            held_drive_ff  <= held_drive_in;
            held_term_ff   <= held_term_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_target_ff   <= req_target_height;
         s1_measured_ff <= req_measured_height;
         s1_throttle_ff <= req_base_throttle;
      end
      if (s1_fire) begin
         rsp_drive_ff   <= held_drive_in;
         rsp_term_ff    <= held_term_in;
         rsp_updated_ff <= calc.update;
      end
   end

   // The error history shifts only when a sample leaves the input register with an update.
   a_history_hold : assert property (@(posedge clock) disable iff (reset)
      !(s1_fire && calc.update) |=> $stable(last_error_ff) && $stable(older_error_ff))
      else $error("error history changed without an update");

   // The oldest error takes the previous error before that one is overwritten.
   a_history_order : assert property (@(posedge clock) disable iff (reset)
      (s1_fire && calc.update) |=> older_error_ff == $past(last_error_ff))
      else $error("older error did not take the previous last error");

   // A freshly loaded response always repeats the held drive and term.
   a_rsp_matches_held : assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_drive_ff == held_drive_ff && rsp_term_ff == held_term_ff)
      else $error("response does not match held outputs");

endmodule

// File: test/incremental_pid_height_hold_core_tb.sv
// Self-checking testbench of the incremental PID height hold core with a predictor and scoreboard.
module incremental_pid_height_hold_core_tb;
   import ipid_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_SAMPLES = 190;
   localparam int REPORT_LIMIT  = 50;

   typedef struct packed {
      logic [HEIGHT_W-1:0] target;
      logic [HEIGHT_W-1:0] measured;
      logic [THR_W-1:0]    throttle;
   } height_sample_t;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic signed [TERM_W-1:0]  term;
      logic                      updated;
   } height_result_t;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [HEIGHT_W-1:0]         req_target_height = '0;
   logic [HEIGHT_W-1:0]         req_measured_height = '0;
   logic [THR_W-1:0]            req_base_throttle = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [DRIVE_W-1:0]   rsp_drive_out;
   logic signed [TERM_W-1:0]    rsp_pid_term;
   logic                        rsp_updated;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DAT_W-1:0]        csr_wdata = '0;

   cfg_type                     ctl;
   logic signed [ERR_W-1:0]     last_error_q;
   logic signed [ERR_W-1:0]     older_error_q;
   logic signed [DRIVE_W-1:0]   held_drive_q;
   logic signed [TERM_W-1:0]    held_term_q;

   height_sample_t              pending_samples[$];
   height_result_t              expected_results[$];

   bit                          idle_enable = 1'b1;
   int                          send_gap = 0;
   int                          stall_gap = 0;
   int                          issued_samples = 0;
   int                          checked_results = 0;
   int                          mismatch_count = 0;
   int                          update_count = 0;
   int                          hold_count = 0;
   int                          saturated_terms = 0;
   int                          settings_count = 0;
   int                          cycle_count = 0;

   incremental_pid_height_hold_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_target_height   (req_target_height),
      .req_measured_height (req_measured_height),
      .req_base_throttle   (req_base_throttle),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_drive_out       (rsp_drive_out),
      .rsp_pid_term        (rsp_pid_term),
      .rsp_updated         (rsp_updated),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", what);
   endtask

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DAT_W-1:0] data);
      case (idx)
         REG_GAIN_P:         ctl.gain_p = data[GAIN_W-1:0];
         REG_GAIN_I:         ctl.gain_i = data[GAIN_W-1:0];
         REG_GAIN_D:         ctl.gain_d = data[GAIN_W-1:0];
         REG_HEIGHT_CEILING: ctl.height_ceiling = data[HEIGHT_W-1:0];
         REG_DEAD_BAND:      ctl.dead_band = data[BAND_W-1:0];
         REG_TERM_FLOOR:     ctl.term_floor = data[FLOOR_W-1:0];
         REG_TERM_CEILING:   ctl.term_ceiling = data[CEIL_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic height_result_t predict_height_step(input height_sample_t s);
      height_result_t      r;
      logic [HEIGHT_W-1:0] goal;
      int                  err;
      int                  mag;
      longint              acc;
      longint              t;
      goal = (s.target > ctl.height_ceiling) ? ctl.height_ceiling : s.target;
      err = int'(goal) - int'(s.measured);
      mag = (err < 0) ? -err : err;
      r.updated = 1'b0;
      if (mag > int'(ctl.dead_band)) begin
         acc = longint'(ctl.gain_p) * (longint'(err) - longint'(last_error_q))
             + longint'(ctl.gain_i) * longint'(err)
             + longint'(ctl.gain_d) * (longint'(err) - 2 * longint'(last_error_q)
                                       + longint'(older_error_q));
         t = acc >>> GAIN_FRAC_BITS;
         if (t > longint'(ctl.term_ceiling)) begin
            t = longint'(ctl.term_ceiling);
            saturated_terms++;
         end else if (t < longint'($signed(ctl.term_floor))) begin
            t = longint'($signed(ctl.term_floor));
            saturated_terms++;
         end
         held_term_q = TERM_W'(t);
         held_drive_q = DRIVE_W'(int'(s.throttle) + int'(held_term_q));
         older_error_q = last_error_q;
         last_error_q = ERR_W'(err);
         r.updated = 1'b1;
      end
      r.drive = held_drive_q;
      r.term = held_term_q;
      return r;
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 9))
         0:             return '0;
         1:             return '1;
         2, 3, 4, 5, 6: return GAIN_W'($urandom_range(0, 600));
         7:             return GAIN_W'($urandom_range(0, 4095));
         default:       return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic height_sample_t random_sample(input int ceiling, input int band);
      height_sample_t s;
      int             goal;
      int             offset;
      int             meas;
      s.throttle = THR_W'($urandom_range(0, 2047));
      s.target = HEIGHT_W'($urandom_range(0, 4095));
      s.measured = HEIGHT_W'($urandom_range(0, 4095));
      case ($urandom_range(0, 9))
         0, 1, 2: ;
         3: s.target = HEIGHT_W'($urandom_range(ceiling, 4095));
         default: begin
            goal = (int'(s.target) > ceiling) ? ceiling : int'(s.target);
            offset = int'($urandom_range(0, 2 * band + 40)) - (band + 20);
            meas = goal + offset;
            if (meas < 0) meas = 0;
            if (meas > 4095) meas = 4095;
            s.measured = HEIGHT_W'(meas);
         end
      endcase
      return s;
   endfunction

   function automatic void queue_sample(input int target, input int measured, input int thr);
      height_sample_t s;
      s.target = HEIGHT_W'(target);
      s.measured = HEIGHT_W'(measured);
      s.throttle = THR_W'(thr);
      pending_samples.push_back(s);
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all(input logic [CSR_DAT_W-1:0] gp, input logic [CSR_DAT_W-1:0] gi,
                            input logic [CSR_DAT_W-1:0] gd, input logic [CSR_DAT_W-1:0] hc,
                            input logic [CSR_DAT_W-1:0] db, input logic [CSR_DAT_W-1:0] tf,
                            input logic [CSR_DAT_W-1:0] tc);
      write_csr(REG_GAIN_P, gp);
      write_csr(REG_GAIN_I, gi);
      write_csr(REG_GAIN_D, gd);
      write_csr(REG_HEIGHT_CEILING, hc);
      write_csr(REG_DEAD_BAND, db);
      write_csr(REG_TERM_FLOOR, tf);
      write_csr(REG_TERM_CEILING, tc);
      settings_count++;
   endtask

   task automatic program_random_setting(output int ceiling, output int band);
      int floor_val;
      int term_ceil;
      case ($urandom_range(0, 9))
         0:       ceiling = 4095;
         1:       ceiling = 0;
         default: ceiling = $urandom_range(200, 4095);
      endcase
      case ($urandom_range(0, 9))
         0:       band = 0;
         1:       band = 255;
         default: band = $urandom_range(0, 60);
      endcase
      case ($urandom_range(0, 9))
         0:       floor_val = -2048;
         1:       floor_val = 0;
         2:       floor_val = $urandom_range(1, 2047);
         default: floor_val = -int'($urandom_range(0, 300));
      endcase
      case ($urandom_range(0, 9))
         0:       term_ceil = 0;
         1:       term_ceil = 2047;
         default: term_ceil = $urandom_range(0, 2047);
      endcase
      write_all(pick_gain(), pick_gain(), pick_gain(),
                {4'($urandom), 12'(ceiling)}, {8'($urandom), 8'(band)},
                {4'($urandom), 12'(floor_val)}, {5'($urandom), 11'(term_ceil)});
      write_csr(REG_UNUSED, 16'($urandom));
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || checked_results < issued_samples)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   always @(posedge clock) begin
      height_sample_t next_sample;
      height_result_t want;
      logic           present;
      if (reset) begin
         ctl.gain_p = GAIN_P_RESET;
         ctl.gain_i = GAIN_I_RESET;
         ctl.gain_d = GAIN_D_RESET;
         ctl.height_ceiling = CEILING_RESET;
         ctl.dead_band = BAND_RESET;
         ctl.term_floor = FLOOR_RESET;
         ctl.term_ceiling = TERM_CEIL_RESET;
         last_error_q = '0;
         older_error_q = '0;
         held_drive_q = '0;
         held_term_q = '0;
         send_gap = 0;
         req_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_wdata);
         if (req_valid && req_ready) begin
            next_sample.target = req_target_height;
            next_sample.measured = req_measured_height;
            next_sample.throttle = req_base_throttle;
            want = predict_height_step(next_sample);
            expected_results.push_back(want);
         end
         present = req_valid && !req_ready;
         if (!present) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_samples.size() != 0) begin
               next_sample = pending_samples.pop_front();
               issued_samples++;
               req_target_height <= next_sample.target;
               req_measured_height <= next_sample.measured;
               req_base_throttle <= next_sample.throttle;
               present = 1'b1;
               if (idle_enable && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 7);
            end
         end
         req_valid <= present;
      end
   end

   always @(posedge clock) begin
      height_result_t want;
      logic           ready_next;
      if (reset) begin
         stall_gap = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked_results++;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result drive_out %0d pid_term %0d",
                                         rsp_drive_out, rsp_pid_term));
            end else begin
               want = expected_results.pop_front();
               if (want.updated) update_count++;
               else hold_count++;
               if (rsp_drive_out !== want.drive)
                  report_mismatch($sformatf("result %0d: drive_out %0d, predicted %0d",
                                            checked_results, rsp_drive_out,
                                            $signed(want.drive)));
               if (rsp_pid_term !== want.term)
                  report_mismatch($sformatf("result %0d: pid_term %0d, predicted %0d",
                                            checked_results, rsp_pid_term,
                                            $signed(want.term)));
               if (rsp_updated !== want.updated)
                  report_mismatch($sformatf("result %0d: updated %0b, predicted %0b",
                                            checked_results, rsp_updated, want.updated));
            end
         end
         if (stall_gap > 0) begin
            stall_gap--;
            ready_next = 1'b0;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall_gap = $urandom_range(1, 7) - 1;
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   initial begin
      int ceiling;
      int band;
      int leftover;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Default settings: deadband edges, ceiling clamp and both saturation limits.
      queue_sample(500, 500, 100);
      queue_sample(500, 480, 0);
      queue_sample(500, 479, 2047);
      queue_sample(4095, 0, 2047);
      queue_sample(0, 4095, 0);
      queue_sample(0, 0, 1024);
      queue_sample(1020, 1000, 0);
      queue_sample(1000, 979, 5);
      queue_sample(4095, 4095, 2047);
      wait_drained();

      write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0FFF, 16'h0000, 16'h0800, 16'h07FF);
      queue_sample(4095, 0, 2047);
      queue_sample(0, 4095, 0);
      queue_sample(2048, 2047, 1024);
      queue_sample(1000, 1000, 7);
      queue_sample(0, 4095, 2047);
      queue_sample(4095, 4094, 0);
      wait_drained();

      // Floor above ceiling, oversized register words and a write to an unused index.
      write_all(16'h0001, 16'h0001, 16'h0001, 16'hF000, 16'hFFFF, 16'hF7FF, 16'hF800);
      write_csr(REG_UNUSED, 16'hFFFF);
      queue_sample(4095, 0, 100);
      queue_sample(100, 255, 100);
      queue_sample(0, 256, 0);
      queue_sample(0, 4095, 2047);
      queue_sample(0, 300, 1);
      wait_drained();

      // Small gain so that the shift rounds negative terms downwards.
      write_all(16'h0001, 16'h0000, 16'h0000, 16'h0FFF, 16'h0000, 16'h0800, 16'h07FF);
      queue_sample(0, 1, 0);
      queue_sample(0, 3, 0);
      queue_sample(5, 0, 0);
      queue_sample(0, 4000, 0);
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         program_random_setting(ceiling, band);
         if (p == RANDOM_PHASES - 1) idle_enable = 1'b0;
         repeat (PHASE_SAMPLES) pending_samples.push_back(random_sample(ceiling, band));
         wait_drained();
      end

      repeat (8) @(posedge clock);
      leftover = expected_results.size();
      if (leftover != 0)
         report_mismatch($sformatf("%0d predicted results never arrived", leftover));
      $display("coverage: %0d samples checked under %0d register settings",
               checked_results, settings_count);
      $display("coverage: %0d updates, %0d held in the deadband, %0d saturated terms",
               update_count, hold_count, saturated_terms);
      if (mismatch_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
